FILE: src/spp_pkg.sv
// Shared types and constants for the scan point projection block.
package spp_pkg;

    // CORDIC datapath widths
    localparam int CW      = 20;
    localparam int ZW      = 34;
    localparam int TAB_LEN = 24;

    // Gain compensation for the CORDIC start vector, Q16
    localparam logic signed [CW-1:0] CORDIC_GAIN = 20'sd39797;

    // Arctangent of 2^-i in 2^32-per-turn units
    localparam logic [29:0] ATAN_TAB [0:TAB_LEN-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10680862,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    // Configuration register indexes
    localparam logic [1:0] CFG_MOUNT_FWD  = 2'd0;
    localparam logic [1:0] CFG_MOUNT_SIDE = 2'd1;
    localparam logic [1:0] CFG_MOUNT_ROT  = 2'd2;

    // Three angle lanes: relative, heading, absolute
    typedef logic [2:0][15:0] t_ang3;

    // Sine and cosine for the three lanes
    typedef struct packed {
        logic [2:0][CW-1:0] c;
        logic [2:0][CW-1:0] s;
    } t_trig;

    // Pose and range carried alongside the CORDIC
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [15:0]        rng;
    } t_side;

endpackage

FILE: src/spp_in_if.sv
// Input channel: one beam with the robot pose.
interface spp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [15:0]        pose_heading;
    logic [15:0]        range;
    logic [15:0]        beam_angle;

    modport source (output valid, pose_x, pose_y, pose_heading, range, beam_angle,
                    input ready);
    modport sink (input valid, pose_x, pose_y, pose_heading, range, beam_angle,
                  output ready);
endinterface

FILE: src/spp_out_if.sv
// Output channel: relative and world frame beam end points.
interface spp_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] rel_x;
    logic signed [16:0] rel_y;
    logic signed [31:0] abs_x;
    logic signed [31:0] abs_y;

    modport source (output valid, rel_x, rel_y, abs_x, abs_y, input ready);
    modport sink (input valid, rel_x, rel_y, abs_x, abs_y, output ready);
endinterface

FILE: src/spp_cordic.sv
// Pipelined three-lane rotation CORDIC, one iteration per stage.
module spp_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  spp_pkg::t_ang3 i_ang,
    input  spp_pkg::t_side i_side,
    output logic           o_valid,
    output spp_pkg::t_trig o_trig,
    output spp_pkg::t_side o_side
);
    import spp_pkg::*;

    localparam int ITER = (ANGLE_BITS < TAB_LEN) ? ANGLE_BITS : TAB_LEN;

    logic signed [CW-1:0] r_x [0:ITER][0:2];
    logic signed [CW-1:0] r_y [0:ITER][0:2];
    logic signed [ZW-1:0] r_z [0:ITER][0:2];
    logic                 r_v [0:ITER];
    t_side                r_sd [0:ITER];

    // Load stage zero with the quadrant-corrected start vector
    for (genvar l = 0; l < 3; l++) begin : g_init
        logic [31:0]          w_u;
        logic                 w_flip;
        logic signed [CW-1:0] n_x;
        logic signed [ZW-1:0] n_z;
        always_comb begin
            w_u    = {i_ang[l], 16'h0000};
            w_flip = w_u[31] ^ w_u[30];
            n_x    = w_flip ? -CORDIC_GAIN : CORDIC_GAIN;
            n_z    = ZW'($signed({w_u[31] ^ w_flip, w_u[30:0]}));
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[0][l] <= n_x;
                r_y[0][l] <= '0;
                r_z[0][l] <= n_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[0] <= i_side;
        end
    end

    // One micro-rotation per stage
    for (genvar k = 0; k < ITER; k++) begin : g_iter
        localparam logic signed [ZW-1:0] ATN = ZW'(ATAN_TAB[k]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sd[k+1] <= r_sd[k];
            end
        end
        for (genvar l = 0; l < 3; l++) begin : g_lane
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!r_z[k][l][ZW-1]) begin
                        r_x[k+1][l] <= r_x[k][l] - (r_y[k][l] >>> k);
                        r_y[k+1][l] <= r_y[k][l] + (r_x[k][l] >>> k);
                        r_z[k+1][l] <= r_z[k][l] - ATN;
                    end else begin
                        r_x[k+1][l] <= r_x[k][l] + (r_y[k][l] >>> k);
                        r_y[k+1][l] <= r_y[k][l] - (r_x[k][l] >>> k);
                        r_z[k+1][l] <= r_z[k][l] + ATN;
                    end
                end
            end
        end
    end

    // Take sine and cosine from the last stage
    for (genvar l = 0; l < 3; l++) begin : g_out
        assign o_trig.c[l] = r_x[ITER][l];
        assign o_trig.s[l] = r_y[ITER][l];
    end

    assign o_valid = r_v[ITER];
    assign o_side  = r_sd[ITER];

endmodule

FILE: src/spp_combine.sv
// Products, rounding, saturation and output register of the projection.
module spp_combine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  spp_pkg::t_trig     i_trig,
    input  spp_pkg::t_side     i_side,
    input  logic signed [15:0] i_fwd,
    input  logic signed [15:0] i_side_off,
    output logic               o_en,
    spp_out_if.source          o_out
);
    import spp_pkg::*;

    logic signed [CW-1:0] w_cr, w_sr, w_ch, w_sh, w_ca, w_sa;
    logic signed [16:0]   w_rng;

    // Product stage
    logic               r_m_valid;
    logic signed [36:0] r_prx, r_pry, r_pa3, r_pb3;
    logic signed [35:0] r_pa1, r_pa2, r_pb1, r_pb2;
    logic signed [31:0] r_m_px, r_m_py;

    // Sum and round stage
    logic               r_s_valid;
    logic signed [16:0] r_s_rx, r_s_ry;
    logic signed [23:0] r_s_ax, r_s_ay;
    logic signed [31:0] r_s_px, r_s_py;
    logic signed [39:0] w_sax, w_say;
    logic signed [37:0] w_srx, w_sry;
    logic signed [21:0] w_rrx, w_rry;
    logic signed [16:0] n_rx, n_ry;

    // Output stage
    logic               r_out_valid;
    logic signed [16:0] r_rx, r_ry;
    logic signed [31:0] r_ax, r_ay;
    logic signed [32:0] w_fax, w_fay;
    logic signed [31:0] n_ax, n_ay;

    // Advance the whole pipe unless the output holds an untaken result
    assign o_en = !r_out_valid || o_out.ready;

    assign w_cr  = $signed(i_trig.c[0]);
    assign w_sr  = $signed(i_trig.s[0]);
    assign w_ch  = $signed(i_trig.c[1]);
    assign w_sh  = $signed(i_trig.s[1]);
    assign w_ca  = $signed(i_trig.c[2]);
    assign w_sa  = $signed(i_trig.s[2]);
    assign w_rng = $signed({1'b0, i_side.rng});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (o_en) begin
            r_m_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_prx  <= w_rng * w_cr;
            r_pry  <= w_rng * w_sr;
            r_pa1  <= w_ch * i_fwd;
            r_pa2  <= w_sh * i_side_off;
            r_pa3  <= w_rng * w_ca;
            r_pb1  <= w_sh * i_fwd;
            r_pb2  <= w_ch * i_side_off;
            r_pb3  <= w_rng * w_sa;
            r_m_px <= i_side.px;
            r_m_py <= i_side.py;
        end
    end

    // Sum, round to nearest and clamp the relative point
    always_comb begin
        w_sax = 40'(r_pa1) + 40'(r_pa2) + 40'(r_pa3) + 40'sd32768;
        w_say = 40'(r_pb1) - 40'(r_pb2) + 40'(r_pb3) + 40'sd32768;
        w_srx = 38'(r_prx) + 38'sd32768;
        w_sry = 38'(r_pry) + 38'sd32768;
        w_rrx = w_srx[37:16];
        w_rry = w_sry[37:16];
        if (w_rrx > 22'sd65535) begin
            n_rx = 17'sd65535;
        end else if (w_rrx < -22'sd65536) begin
            n_rx = -17'sd65536;
        end else begin
            n_rx = w_rrx[16:0];
        end
        if (w_rry > 22'sd65535) begin
            n_ry = 17'sd65535;
        end else if (w_rry < -22'sd65536) begin
            n_ry = -17'sd65536;
        end else begin
            n_ry = w_rry[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (o_en) begin
            r_s_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_s_rx <= n_rx;
            r_s_ry <= n_ry;
            r_s_ax <= w_sax[39:16];
            r_s_ay <= w_say[39:16];
            r_s_px <= r_m_px;
            r_s_py <= r_m_py;
        end
    end

    // Add the pose and saturate to 32 bits
    always_comb begin
        w_fax = 33'(r_s_px) + 33'(r_s_ax);
        w_fay = 33'(r_s_py) + 33'(r_s_ay);
        if (w_fax[32] != w_fax[31]) begin
            n_ax = w_fax[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            n_ax = w_fax[31:0];
        end
        if (w_fay[32] != w_fay[31]) begin
            n_ay = w_fay[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            n_ay = w_fay[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_en) begin
            r_out_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_rx <= r_s_rx;
            r_ry <= r_s_ry;
            r_ax <= n_ax;
            r_ay <= n_ay;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.rel_x = r_rx;
    assign o_out.rel_y = r_ry;
    assign o_out.abs_x = r_ax;
    assign o_out.abs_y = r_ay;

    // A held output keeps the inner stages frozen
    a_hold_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_en |=> $stable(r_s_valid) && $stable(r_m_valid))
        else $error("inner stage moved during output hold");

    // Valid flows one stage per advance
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_en && r_s_valid |=> r_out_valid)
        else $error("result lost between sum and output stage");

endmodule

FILE: src/scan_point_projection.sv
// Top level of the scan point projection: config, angle stage, CORDIC, combine.
//
// Channel   Direction  Transfer when      Payload
// i_in      in         valid && ready     pose_x, pose_y, pose_heading, range, beam_angle
// o_out     out        valid && ready     rel_x, rel_y, abs_x, abs_y
// i_cfg_*   in         i_cfg_we           index 0..2, 16-bit data
//
// One beam enters per cycle unless the output holds; the pipe is the
// angle stage, one-iteration-per-stage CORDIC, then product, sum and
// output stages. All stages advance together; when the output holds an
// untaken result the whole pipe and the input ready hold. Synchronous
// active-low reset clears valid bits and the mount registers.
module scan_point_projection #(
    parameter int ANGLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    spp_in_if.sink      i_in,
    spp_out_if.source   o_out
);
    import spp_pkg::*;

    logic signed [15:0] r_fwd, r_side;
    logic [15:0]        r_rot;
    logic               w_en;
    logic               r_a_valid;
    t_ang3              r_ang;
    t_side              r_side_data;
    logic               w_c_valid;
    t_trig              w_trig;
    t_side              w_c_side;

    // Write mount registers, ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd  <= '0;
            r_side <= '0;
            r_rot  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MOUNT_FWD:  r_fwd  <= i_cfg_data;
                CFG_MOUNT_SIDE: r_side <= i_cfg_data;
                CFG_MOUNT_ROT:  r_rot  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_in.ready = w_en;

    // Angle stage: form the three wrapped angles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ang[0]        <= i_in.beam_angle + r_rot;
            r_ang[1]        <= i_in.pose_heading;
            r_ang[2]        <= i_in.pose_heading + r_rot + i_in.beam_angle;
            r_side_data.px  <= i_in.pose_x;
            r_side_data.py  <= i_in.pose_y;
            r_side_data.rng <= i_in.range;
        end
    end

    spp_cordic #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_a_valid),
        .i_ang   (r_ang),
        .i_side  (r_side_data),
        .o_valid (w_c_valid),
        .o_trig  (w_trig),
        .o_side  (w_c_side)
    );

    spp_combine u_combine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_c_valid),
        .i_trig     (w_trig),
        .i_side     (w_c_side),
        .i_fwd      (r_fwd),
        .i_side_off (r_side),
        .o_en       (w_en),
        .o_out      (o_out)
    );

    // An accepted beam lands in the angle stage
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_a_valid)
        else $error("accepted beam missing from angle stage");

    // Reset leaves the pipe empty
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_a_valid && !o_out.valid)
        else $error("valid bit survived reset");

endmodule
